### sv/vwd_pkg.sv
// Shared types and widths for the vertex weld/dedup block.
`timescale 1ns / 1ps

package vwd_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int RADIUS_W      = COORD_WIDTH - 1;
  localparam int LIM_W         = 2 * RADIUS_W;
  localparam int SQ_W          = 2 * COORD_WIDTH;
  localparam int SUM_W         = SQ_W + 2;
  localparam int REMAP_W       = 8;
  localparam int DEFAULT_DEPTH = 256;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } vec_t;

  typedef struct packed {
    logic                          start_mesh;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } vtx_t;

  typedef struct packed {
    logic [REMAP_W-1:0] remap_index;
    logic               is_new;
    logic               table_full;
  } res_t;

endpackage

### sv/vwd_cell.sv
// One table entry with its distance compare pipeline and scan token stage.
`timescale 1ns / 1ps

module vwd_cell import vwd_pkg::*; #(
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  vec_t          query,
  input  logic [LIM_W-1:0] limit,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  logic          chain_en,
  input  logic          tok_in,
  output logic          tok_out,
  output logic          hit
);

  vec_t                   ent;
  logic [COORD_WIDTH-1:0] ad_x, ad_y, ad_z;
  logic [SQ_W-1:0]        sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]       sum;
  logic                   match;
  logic                   tok;

  function automatic logic [COORD_WIDTH-1:0] abs_diff(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    logic signed [COORD_WIDTH:0] d;
    logic signed [COORD_WIDTH:0] n;
    d = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
    n = -d;
    return d[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(IDX))) begin
      ent <= query;
    end
  end

  // distance pipeline: abs diff, square, sum and compare
  always_ff @(posedge clk) begin
    ad_x  <= abs_diff(query.x, ent.x);
    ad_y  <= abs_diff(query.y, ent.y);
    ad_z  <= abs_diff(query.z, ent.z);
    sq_x  <= SQ_W'(ad_x * ad_x);
    sq_y  <= SQ_W'(ad_y * ad_y);
    sq_z  <= SQ_W'(ad_z * ad_z);
    match <= (sum <= SUM_W'(limit));
  end

  assign sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= chain_en & tok_in;
    end
  end

  // stop the token at the first matching entry
  assign hit     = tok & match;
  assign tok_out = tok & ~match;

endmodule

### sv/vertex_weld_dedup.sv
// Top level: vertex weld/dedup with a chain of compare cells and a scan sequencer.
`timescale 1ns / 1ps
//
//  channel   signals                          direction  transaction
//  vtx       vtx_valid / vtx_ready / vtx      in         one vertex (vtx_t)
//  res       res_valid / res_ready / res      out        one remap result (res_t)
//  cfg       cfg_we / cfg_wdata               in         weld radius write
//
//  One vertex at a time. After acceptance the distance pipeline in every cell fills,
//  then a token walks the cell chain one entry per cycle.
//  The gap between accepted vertices is set by the token walk: it stops at a matching
//  entry, or runs over every stored entry on a miss (no walk with an empty table).
//  Reset is synchronous and clears count, radius and control; entries stay as they are.
//  A stalled result holds in the output register; the next vertex is taken meanwhile.

module vertex_weld_dedup import vwd_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vtx_valid,
  output logic                vtx_ready,
  input  vtx_t                vtx,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_wdata
);

  localparam int IW   = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam logic [1:0] FILL_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  logic [1:0]          fill_cnt;
  logic [IW-1:0]       scan_idx;
  logic [CNTW-1:0]     cnt;
  logic [CNTW-1:0]     cnt_m1;
  logic                found;
  vec_t                query;
  logic [RADIUS_W-1:0] radius;
  logic [LIM_W-1:0]    limit;

  logic                launch;
  logic                chain_en;
  logic                out_free;
  logic                is_full;
  logic                wr_en;
  logic                any_hit;
  logic [IW-1:0]       sel_idx;
  logic [31:0]         sel_ext;
  logic [TABLE_DEPTH-1:0] hit;
  logic [TABLE_DEPTH-1:0] tok_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      limit  <= '0;
    end else begin
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      limit <= LIM_W'(radius * radius);
    end
  end

  assign vtx_ready = (state == S_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign launch    = (state == S_FILL) && (fill_cnt == FILL_LAST) && (cnt != '0);
  assign chain_en  = launch || (state == S_SCAN);
  assign is_full   = (cnt == CNTW'(TABLE_DEPTH));
  assign wr_en     = (state == S_DONE) && out_free && !found && !is_full;
  assign cnt_m1    = cnt - CNTW'(1);
  assign any_hit   = |hit;
  assign sel_idx   = found ? scan_idx : cnt[IW-1:0];
  assign sel_ext   = 32'(sel_idx);

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    vwd_cell #(
      .IW  (IW),
      .IDX (j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .query    (query),
      .limit    (limit),
      .wr_en    (wr_en),
      .wr_idx   (cnt[IW-1:0]),
      .chain_en (chain_en),
      .tok_in   ((j == 0) ? launch : tok_out[(j == 0) ? 0 : j-1]),
      .tok_out  (tok_out[j]),
      .hit      (hit[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
      fill_cnt  <= '0;
      scan_idx  <= '0;
      found     <= 1'b0;
    end else begin
      // drop valid on a transaction unless a new result loads in the same cycle
      if (res_valid && res_ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (vtx_valid) begin
            query.x  <= vtx.pos_x;
            query.y  <= vtx.pos_y;
            query.z  <= vtx.pos_z;
            fill_cnt <= '0;
            if (vtx.start_mesh) begin
              cnt <= '0;
            end
            state <= S_FILL;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 2'd1;
          if (fill_cnt == FILL_LAST) begin
            scan_idx <= '0;
            found    <= 1'b0;
            state    <= (cnt == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            found <= 1'b1;
            state <= S_DONE;
          end else if (scan_idx == cnt_m1[IW-1:0]) begin
            state <= S_DONE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            if (found) begin
              res.remap_index <= sel_ext[REMAP_W-1:0];
              res.is_new      <= 1'b0;
              res.table_full  <= 1'b0;
            end else if (is_full) begin
              res.remap_index <= '0;
              res.is_new      <= 1'b0;
              res.table_full  <= 1'b1;
            end else begin
              res.remap_index <= sel_ext[REMAP_W-1:0];
              res.is_new      <= 1'b1;
              res.table_full  <= 1'b0;
              cnt             <= cnt + CNTW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(hit))
    else $error("more than one cell reports a hit");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CNTW'(scan_idx) < cnt))
    else $error("scan past last stored entry");

  a_append_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (cnt == $past(cnt) + CNTW'(1)))
    else $error("append did not advance the count");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_new && res.table_full))
    else $error("result flagged both new and full");
`endif

endmodule

### verif/tb_vertex_weld_dedup.sv
// Self-checking testbench for vertex_weld_dedup: directed table, random meshes, table fill.
`timescale 1ns / 1ps

module tb_vertex_weld_dedup;
  import vwd_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t CMAX  = 24'sh7FFFFF;
  localparam coord_t CMIN  = 24'sh800000;
  localparam coord_t CNEG1 = 24'shFFFFFF;
  localparam logic [RADIUS_W-1:0] R_MAX = '1;
  localparam logic [RADIUS_W-1:0] R_ONE = 23'd4096;

  typedef struct packed {
    logic                set_r;
    logic [RADIUS_W-1:0] r;
    logic                start;
    coord_t              x, y, z;
    logic                typed;
    logic [REMAP_W-1:0]  idx;
    logic                is_new;
    logic                full;
  } weld_row_t;

  // set_r, radius, start, x, y, z, typed, remap_index, is_new, table_full
  weld_row_t weld_rows [24] = '{
    '{0, 0,     1, 0,     0,     0,     1, 0, 1, 0},
    '{0, 0,     0, 0,     0,     0,     1, 0, 0, 0},
    '{0, 0,     0, CMAX,  CMAX,  CMAX,  1, 1, 1, 0},
    '{0, 0,     0, CMIN,  CMIN,  CMIN,  1, 2, 1, 0},
    '{0, 0,     0, CMIN,  CMIN,  CMIN,  1, 2, 0, 0},
    '{0, 0,     0, CMAX,  CMIN,  0,     1, 3, 1, 0},
    '{0, 0,     0, 1,     0,     0,     1, 4, 1, 0},
    '{0, 0,     1, CMAX,  CMAX,  CMAX,  1, 0, 1, 0},
    '{0, 0,     0, 0,     0,     0,     1, 1, 1, 0},
    '{1, R_MAX, 1, 0,     0,     0,     1, 0, 1, 0},
    '{0, 0,     0, CMAX,  0,     0,     1, 0, 0, 0},
    '{0, 0,     0, CMIN,  0,     0,     1, 1, 1, 0},
    '{0, 0,     0, CMIN,  CMIN,  CMIN,  0, 0, 0, 0},
    '{0, 0,     0, CMAX,  CMAX,  CMAX,  0, 0, 0, 0},
    '{1, R_ONE, 1, 0,     0,     0,     1, 0, 1, 0},
    '{0, 0,     0, 8192,  0,     0,     1, 1, 1, 0},
    '{0, 0,     0, 4096,  0,     0,     1, 0, 0, 0},
    '{0, 0,     0, 2896,  2896,  0,     0, 0, 0, 0},
    '{0, 0,     0, 6144,  1,     0,     0, 0, 0, 0},
    '{0, 0,     0, 4097,  0,     0,     0, 0, 0, 0},
    '{1, 1,     1, 5,     5,     5,     1, 0, 1, 0},
    '{0, 0,     0, 6,     5,     5,     1, 0, 0, 0},
    '{0, 0,     0, 6,     6,     5,     0, 0, 0, 0},
    '{0, 0,     0, CMIN,  CMAX,  CNEG1, 0, 0, 0, 0}
  };

  logic                clk;
  logic                rst;
  logic                vtx_valid;
  logic                vtx_ready;
  vtx_t                vtx;
  logic                res_valid;
  logic                res_ready = 1'b0;
  res_t                res;
  logic                cfg_we;
  logic [RADIUS_W-1:0] cfg_wdata;

  // predictor state
  coord_t              weld_tab_x [DEPTH];
  coord_t              weld_tab_y [DEPTH];
  coord_t              weld_tab_z [DEPTH];
  int                  weld_count;
  logic [RADIUS_W-1:0] weld_radius_q;

  res_t   remap_expect_q [$];
  vtx_t   mesh_hist [$];
  coord_t mesh_cx, mesh_cy, mesh_cz;

  bit quiet;
  int ready_pct;
  int ready_hold;
  int mismatch_count;
  int sent_count;
  int checked_count;
  int appended_count;
  int welded_count;
  int dropped_count;
  int radius_writes;

  vertex_weld_dedup #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic res_t weld_predict(vtx_t v);
    res_t            r;
    longint unsigned limit, dsq;
    longint          dx, dy, dz;
    int              j;
    r = '0;
    if (v.start_mesh) weld_count = 0;
    limit = longint'(weld_radius_q) * longint'(weld_radius_q);
    for (j = 0; j < weld_count; j++) begin
      dx = longint'($signed(v.pos_x)) - longint'(weld_tab_x[j]);
      dy = longint'($signed(v.pos_y)) - longint'(weld_tab_y[j]);
      dz = longint'($signed(v.pos_z)) - longint'(weld_tab_z[j]);
      // below 2^50, so the 64-bit arithmetic never overflows
      dsq = dx * dx + dy * dy + dz * dz;
      if (dsq <= limit) begin
        r.remap_index = j[REMAP_W-1:0];
        return r;
      end
    end
    if (weld_count >= DEPTH) begin
      r.table_full = 1'b1;
      return r;
    end
    weld_tab_x[weld_count] = v.pos_x;
    weld_tab_y[weld_count] = v.pos_y;
    weld_tab_z[weld_count] = v.pos_z;
    r.remap_index = weld_count[REMAP_W-1:0];
    r.is_new = 1'b1;
    weld_count++;
    return r;
  endfunction

  task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatch_count++;
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (remap_expect_q.size() == 0) begin
      note_mismatch("result with no vertex pending", 64'(0), 64'(got));
    end else begin
      want = remap_expect_q.pop_front();
      checked_count++;
      if (got.remap_index !== want.remap_index)
        note_mismatch("remap_index", 64'(want.remap_index), 64'(got.remap_index));
      if (got.is_new !== want.is_new)
        note_mismatch("is_new", 64'(want.is_new), 64'(got.is_new));
      if (got.table_full !== want.table_full)
        note_mismatch("table_full", 64'(want.table_full), 64'(got.table_full));
    end
  endtask

  // result side: check each transaction, stall in random bursts
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) check_result(res);
    if (ready_hold > 0) ready_hold--;
    if (ready_hold == 0) begin
      if (!quiet && $urandom_range(0, 99) < ready_pct) begin
        ready_hold = $urandom_range(1, 14);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // hold valid after acceptance; the caller decides whether to drop it
  task automatic push_vertex(vtx_t v, bit use_typed, res_t typed_res);
    res_t want;
    vtx <= v;
    vtx_valid <= 1'b1;
    do @(posedge clk); while (vtx_ready !== 1'b1);
    want = weld_predict(v);
    if (use_typed) want = typed_res;
    remap_expect_q.insert(remap_expect_q.size(), want);
    sent_count++;
    if (want.is_new) appended_count++;
    else if (want.table_full) dropped_count++;
    else welded_count++;
  endtask

  task automatic maybe_idle(int pct);
    if (!quiet && $urandom_range(0, 99) < pct) begin
      vtx_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    vtx_valid <= 1'b0;
    do @(posedge clk); while (remap_expect_q.size() != 0);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    cfg_wdata <= r;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    weld_radius_q = r;
    radius_writes++;
  endtask

  function automatic coord_t jitter(coord_t base, int span);
    int c;
    c = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    return c[COORD_WIDTH-1:0];
  endfunction

  // mostly near-copies and clustered points so merges happen; some full-range noise
  function automatic vtx_t next_vertex(bit first);
    vtx_t v;
    vtx_t h;
    int   span;
    int   pick;
    v.start_mesh = first || ($urandom_range(0, 49) == 0);
    if (v.start_mesh) begin
      mesh_hist.delete();
      mesh_cx = COORD_WIDTH'($urandom());
      mesh_cy = COORD_WIDTH'($urandom());
      mesh_cz = COORD_WIDTH'($urandom());
    end
    pick = $urandom_range(0, 9);
    if (pick < 4 && mesh_hist.size() != 0) begin
      h = mesh_hist[$urandom_range(0, mesh_hist.size() - 1)];
      span = (pick == 0) ? 0 : ($urandom_range(0, 3) == 0) ? 1 : int'(weld_radius_q) + 1;
      v.pos_x = jitter(h.pos_x, span);
      v.pos_y = jitter(h.pos_y, span);
      v.pos_z = jitter(h.pos_z, span);
    end else if (pick < 7) begin
      span = 4 * int'(weld_radius_q) + 64;
      if (span > (1 << 23)) span = 1 << 23;
      v.pos_x = jitter(mesh_cx, span);
      v.pos_y = jitter(mesh_cy, span);
      v.pos_z = jitter(mesh_cz, span);
    end else begin
      v.pos_x = COORD_WIDTH'($urandom());
      v.pos_y = COORD_WIDTH'($urandom());
      v.pos_z = COORD_WIDTH'($urandom());
    end
    mesh_hist.insert(mesh_hist.size(), v);
    return v;
  endfunction

  task automatic random_meshes(logic [RADIUS_W-1:0] radius, int n, int gap_pct,
                               int stall_pct);
    int   left;
    int   msize;
    int   i;
    res_t none;
    none = '0;
    wait_drain();
    write_radius(radius);
    ready_pct = stall_pct;
    left = n;
    while (left > 0) begin
      msize = $urandom_range(2, 20);
      for (i = 0; i < msize && left > 0; i++) begin
        push_vertex(next_vertex(i == 0), 1'b0, none);
        left--;
        if (!quiet && $urandom_range(0, 99) < 2) wait_drain();
        else maybe_idle(gap_pct);
      end
    end
  endtask

  // fill every entry, then hit the full table with repeats and fresh points; the fifth fresh point starts a new mesh
  task automatic fill_table();
    vtx_t v;
    vtx_t logged [$];
    res_t none;
    int   i;
    none = '0;
    wait_drain();
    write_radius('0);
    ready_pct = 10;
    for (i = 0; i < DEPTH; i++) begin
      v.start_mesh = (i == 0);
      v.pos_x = COORD_WIDTH'((i << 14) + $urandom_range(0, 16383));
      v.pos_y = COORD_WIDTH'($urandom());
      v.pos_z = COORD_WIDTH'($urandom());
      push_vertex(v, 1'b0, none);
      logged.insert(logged.size(), v);
      maybe_idle(5);
    end
    for (i = 0; i < 3; i++) begin
      v = (i == 0) ? logged[0] : (i == 1) ? logged[DEPTH-1]
                                          : logged[$urandom_range(1, DEPTH - 2)];
      v.start_mesh = 1'b0;
      push_vertex(v, 1'b0, none);
      maybe_idle(10);
    end
    for (i = 0; i < 6; i++) begin
      v.start_mesh = (i == 4);
      v.pos_x = COORD_WIDTH'($urandom());
      v.pos_y = COORD_WIDTH'($urandom());
      v.pos_z = COORD_WIDTH'($urandom());
      push_vertex(v, 1'b0, none);
      maybe_idle(10);
    end
  endtask

  initial begin
    weld_row_t row;
    vtx_t      v;
    res_t      want;
    int        k;
    rst <= 1'b1;
    vtx_valid <= 1'b0;
    vtx <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    weld_count = 0;
    weld_radius_q = '0;
    ready_pct = 20;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 24; k++) begin
      row = weld_rows[k];
      if (row.set_r) begin
        wait_drain();
        write_radius(row.r);
      end
      v.start_mesh = row.start;
      v.pos_x = row.x;
      v.pos_y = row.y;
      v.pos_z = row.z;
      want.remap_index = row.idx;
      want.is_new = row.is_new;
      want.table_full = row.full;
      push_vertex(v, row.typed, want);
      maybe_idle(30);
    end

    random_meshes('0, 60, 20, 20);
    random_meshes(R_MAX, 50, 10, 0);
    random_meshes(23'd1, 50, 0, 30);
    random_meshes(RADIUS_W'($urandom_range(2, 8191)), 60, 25, 25);
    fill_table();
    random_meshes(RADIUS_W'($urandom_range(0, 8388607)), 50, 15, 15);
    random_meshes(RADIUS_W'($urandom_range(256, 65535)), 50, 20, 20);
    quiet = 1'b1;
    random_meshes(RADIUS_W'($urandom_range(0, 4095)), 60, 0, 0);

    wait_drain();
    repeat (300) @(posedge clk);

    $display("Sent %0d vertices under %0d weld radius settings, %0d results checked.",
             sent_count, radius_writes, checked_count);
    $display("Appended %0d, welded %0d, dropped on a full table %0d; %0d mismatches.",
             appended_count, welded_count, dropped_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
